@@ design/apel_pkg.sv @@
// Shared types and constants of the aging priority event list.
package apel_pkg;

    // Field widths of one list entry.
    localparam int CODE_W = 16;
    localparam int PRIO_W = 8;
    localparam int LIFE_W = 16;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_STEP     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_LIMIT = 4'd1;
    localparam logic [15:0] AGE_STEP_RESET     = 16'd50;
    localparam logic [4:0]  REPORT_LIMIT_RESET = 5'd16;
    localparam logic [4:0]  MAX_RESULTS        = 5'd16;

    // Input operation codes carried on tuser.
    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // One list entry.
    typedef struct packed {
        logic              used;
        logic [CODE_W-1:0] code;
        logic [PRIO_W-1:0] prio;
        logic [LIFE_W-1:0] life;
    } t_entry;

    // Where a cell takes its next content from.
    typedef enum logic [2:0] {
        SRC_HOLD,
        SRC_LEFT,
        SRC_RIGHT,
        SRC_NEW,
        SRC_AGE
    } t_src;

    // Values broadcast to every cell.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [PRIO_W-1:0] prio;
        logic [LIFE_W-1:0] life;
        logic [15:0]       age_step;
    } t_bcast;

endpackage

@@ design/apel_cell.sv @@
// One cell of the event list chain: holds one entry and moves it on command.
module apel_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  apel_pkg::t_src   i_src,
    input  apel_pkg::t_bcast i_bcast,
    input  apel_pkg::t_entry i_left,
    input  apel_pkg::t_entry i_right,
    output apel_pkg::t_entry o_entry,
    output logic            o_match,
    output logic            o_gt
);
    import apel_pkg::*;

    logic              r_used;
    logic [CODE_W-1:0] r_code;
    logic [PRIO_W-1:0] r_prio;
    logic [LIFE_W-1:0] r_life;
    t_entry            n_entry;

    // Local compares against the broadcast event.
    assign o_match = r_used && (r_code == i_bcast.code);
    assign o_gt    = r_used && (r_prio > i_bcast.prio);

    assign o_entry = '{used: r_used, code: r_code, prio: r_prio, life: r_life};

    // Next content selection.
    always_comb begin
        n_entry = o_entry;
        case (i_src)
            SRC_LEFT:  n_entry = i_left;
            SRC_RIGHT: n_entry = i_right;
            SRC_NEW: begin
                n_entry.used = 1'b1;
                n_entry.code = i_bcast.code;
                n_entry.prio = i_bcast.prio;
                n_entry.life = i_bcast.life;
            end
            SRC_AGE: begin
                n_entry.used = r_used && (r_life > i_bcast.age_step);
                n_entry.life = r_life - i_bcast.age_step;
            end
            default:   n_entry = o_entry;
        endcase
    end

    // Occupancy flag is control state and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else begin
            r_used <= n_entry.used;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_code <= n_entry.code;
        r_prio <= n_entry.prio;
        r_life <= n_entry.life;
    end

endmodule

@@ design/aging_priority_event_list_unit.sv @@
// Top level of the aging priority event list: control sequencer and cell chain.
//
// Usage: items arrive on the s_axis channel; tuser selects the operation
// (report an event or tick), tdata carries code, priority and lifetime.
// A report is accepted in the idle state and updates the chain in the
// report state, and produces no output. A tick ages all cells together,
// then removes one gap per cycle until the list is packed, then, if
// entries remain, rotates the chain once around, presenting cell 0 on
// m_axis during the first min(entries, limit) steps, where limit is
// report_limit clamped to 1..16. An empty list after aging yields one
// result with valid_res low and tlast. s_axis_tready is high only while
// no item is in progress. A stalled m_axis receiver freezes the rotation
// while a result is pending; the finished result waits in the output
// register. The cfg channel is always ready; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Synchronous active-low reset empties the list and loads age_step 50
// and report_limit 16.
module aging_priority_event_list_unit #(
    parameter int LIST_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // event_code[15:0], priority_req[23:16], lifetime[39:24]
    input  logic        s_axis_tuser,  // operation[0]
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // valid_res[0], out_code[16:1], out_priority[24:17],
                                       // remaining_life[40:25], zero fill[47:41]
    output logic        m_axis_tlast,  // last
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [apel_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import apel_pkg::*;

    localparam int KW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = (KW + 1 > 5) ? KW + 1 : 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REPORT,
        S_AGE,
        S_COMPACT,
        S_EMPTY,
        S_ROTATE
    } t_state;

    t_state            r_state;
    logic [15:0]       r_age_step;
    logic [4:0]        r_report_limit;
    logic [CODE_W-1:0] r_code;
    logic [PRIO_W-1:0] r_prio;
    logic [LIFE_W-1:0] r_life;
    logic [KW-1:0]     r_k;
    logic              r_out_valid;
    t_entry            r_out;
    logic              r_out_last;

    t_bcast            w_bcast;
    t_entry            w_entry [LIST_DEPTH];
    t_entry            w_left  [LIST_DEPTH];
    t_entry            w_right [LIST_DEPTH];
    t_src              w_src   [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] w_used;
    logic [LIST_DEPTH-1:0] w_match;
    logic [LIST_DEPTH-1:0] w_gt;
    logic [LIST_DEPTH-1:0] w_pre_gt;
    logic [LIST_DEPTH-1:0] w_pre_hole;
    logic              w_any_match;
    logic              w_full;
    logic              w_compact;
    logic [4:0]        w_limit;
    logic              w_emit;
    logic              w_last;
    logic              w_out_free;
    logic              w_out_load;
    logic              w_in_acc;

    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;

    assign w_bcast = '{code: r_code, prio: r_prio, life: r_life, age_step: r_age_step};

    // Neighbor wiring of the chain; the tail wraps to cell 0 during rotation.
    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            w_used[i]  = w_entry[i].used;
            w_left[i]  = (i > 0) ? w_entry[(i > 0) ? i - 1 : 0] : '0;
            if (i < LIST_DEPTH - 1) begin
                w_right[i] = w_entry[(i < LIST_DEPTH - 1) ? i + 1 : 0];
            end else begin
                w_right[i] = (r_state == S_ROTATE) ? w_entry[0] : '0;
            end
        end
    end

    // Inclusive prefix flags: any greater priority, any gap at or below a cell.
    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            w_pre_gt[i]   = |(w_gt & ({LIST_DEPTH{1'b1}} >> (LIST_DEPTH - 1 - i)));
            w_pre_hole[i] = |(~w_used & ({LIST_DEPTH{1'b1}} >> (LIST_DEPTH - 1 - i)));
        end
    end

    assign w_any_match = |w_match;
    assign w_full      = w_used[LIST_DEPTH-1];
    assign w_compact   = ~|(~w_used[LIST_DEPTH-2:0] & w_used[LIST_DEPTH-1:1]);

    // Per-cell source selection for each phase.
    always_comb begin
        logic prev_gt;
        logic prev_used;
        for (int i = 0; i < LIST_DEPTH; i++) begin
            prev_gt   = (i > 0) ? w_pre_gt[(i > 0) ? i - 1 : 0] : 1'b0;
            prev_used = (i > 0) ? w_used[(i > 0) ? i - 1 : 0] : 1'b1;
            w_src[i]  = SRC_HOLD;
            unique case (r_state)
                S_REPORT: begin
                    if (w_any_match) begin
                        if (w_match[i]) w_src[i] = SRC_NEW;
                    end else if (!w_full) begin
                        if (w_pre_gt[LIST_DEPTH-1]) begin
                            if (prev_gt) begin
                                w_src[i] = SRC_LEFT;
                            end else if (w_gt[i]) begin
                                w_src[i] = SRC_NEW;
                            end
                        end else if (!w_used[i] && prev_used) begin
                            w_src[i] = SRC_NEW;
                        end
                    end
                end
                S_AGE:     w_src[i] = SRC_AGE;
                S_COMPACT: begin
                    if (!w_compact && w_pre_hole[i]) w_src[i] = SRC_RIGHT;
                end
                S_ROTATE: begin
                    if (!(w_emit && !w_out_free)) w_src[i] = SRC_RIGHT;
                end
                default:   w_src[i] = SRC_HOLD;
            endcase
        end
    end

    // The chain of cells.
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        apel_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_src   (w_src[g]),
            .i_bcast (w_bcast),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .o_entry (w_entry[g]),
            .o_match (w_match[g]),
            .o_gt    (w_gt[g])
        );
    end

    // Emission control during rotation: cell 0 holds original entry r_k.
    always_comb begin
        if (r_report_limit == 5'd0) begin
            w_limit = 5'd1;
        end else if (r_report_limit > MAX_RESULTS) begin
            w_limit = MAX_RESULTS;
        end else begin
            w_limit = r_report_limit;
        end
    end

    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_emit     = (CW'(r_k) < CW'(w_limit)) && w_used[0];
    assign w_last     = ((CW'(r_k) + CW'(1)) == CW'(w_limit)) ||
                        (r_k == KW'(LIST_DEPTH - 1)) || !w_used[1];

    // The output register loads when free: the empty result or an emitted entry.
    assign w_out_load = w_out_free &&
                        ((r_state == S_EMPTY) || ((r_state == S_ROTATE) && w_emit));

    // Sequencer, configuration registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_age_step     <= AGE_STEP_RESET;
            r_report_limit <= REPORT_LIMIT_RESET;
            r_k            <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_AGE_STEP:     r_age_step     <= i_cfg_data;
                    CFG_REPORT_LIMIT: r_report_limit <= i_cfg_data[4:0];
                    default:          ;
                endcase
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= (s_axis_tuser == OP_TICK) ? S_AGE : S_REPORT;
                    end
                end
                S_REPORT: r_state <= S_IDLE;
                S_AGE:    r_state <= S_COMPACT;
                S_COMPACT: begin
                    if (w_compact) begin
                        r_k     <= '0;
                        r_state <= w_used[0] ? S_ROTATE : S_EMPTY;
                    end
                end
                S_EMPTY: begin
                    if (w_out_free) begin
                        r_out_last  <= 1'b1;
                        r_out       <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                S_ROTATE: begin
                    if (!(w_emit && !w_out_free)) begin
                        if (w_emit) begin
                            r_out_last  <= w_last;
                            r_out       <= w_entry[0];
                        end
                        r_k <= r_k + KW'(1);
                        if (r_k == KW'(LIST_DEPTH - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    // Input fields are captured on acceptance.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_code <= s_axis_tdata[15:0];
            r_prio <= s_axis_tdata[23:16];
            r_life <= s_axis_tdata[39:24];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {7'd0, r_out.life, r_out.prio, r_out.code, r_out.used};

    // The list stays packed whenever no item is in progress.
    a_packed_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> w_compact)
        else $error("event list has a gap while idle");

    // A new event on a full list is dropped and leaves occupancy alone.
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REPORT && !w_any_match && w_full) |=> $stable(w_used))
        else $error("full list changed on dropped event");

    // The empty-list result is always the last of its tick.
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.used) |-> r_out_last)
        else $error("invalid result without last");

    // The empty path is only taken with no entry left.
    a_empty_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMPTY) |-> !w_used[0])
        else $error("empty result with entries present");

endmodule
